[design/ep2cal_pkg.sv]
// Package with constants, widths and calendar helper functions for the epoch converter.
`timescale 1ns / 1ps

package ep2cal_pkg;

   // Field widths.
   localparam int STAMP_W   = 32;
   localparam int OFFSET_W  = 17;
   localparam int YEAR_W    = 12;
   localparam int MONTH_W   = 4;
   localparam int DAY_W     = 5;
   localparam int WEEKDAY_W = 3;
   localparam int HOURS_W   = 5;
   localparam int MINUTES_W = 6;
   localparam int SECONDS_W = 6;

   // Calendar constants.
   localparam logic [STAMP_W-1:0]  SecsPerDay   = 32'd86400;
   localparam logic [STAMP_W-1:0]  SecsPerHour  = 32'd3600;
   localparam logic [STAMP_W-1:0]  SecsPerMin   = 32'd60;
   localparam logic [STAMP_W-1:0]  DaysPerWeek  = 32'd7;
   localparam logic [YEAR_W-1:0]   BaseYear     = 12'd1970;
   localparam logic [YEAR_W-1:0]   LastYear     = 12'd2106;
   localparam logic [YEAR_W-1:0]   CenturyNoLeap = 12'd2100;
   localparam logic [OFFSET_W-1:0] OffsetReset  = 17'd28800;
   localparam logic [MONTH_W-1:0]  LastMonthIdx = 4'd11;

   // Year of the block's range, 1970 to 2106. In that range the only century
   // year that is not a leap year is 2100; 2000 is divisible by 400.
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      logic result;
      result = (year[1:0] == 2'b00) && (year != CenturyNoLeap);
      return result;
   endfunction

   // Length of a year in days.
   function automatic logic [8:0] year_len(input logic [YEAR_W-1:0] year);
      logic [8:0] result;
      result = is_leap(year) ? 9'd366 : 9'd365;
      return result;
   endfunction

   // Length of a month in days; month index 0 is January.
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] mon, input logic leap);
      logic [4:0] result;
      case (mon)
         4'd0:    result = 5'd31;
         4'd1:    result = leap ? 5'd29 : 5'd28;
         4'd2:    result = 5'd31;
         4'd3:    result = 5'd30;
         4'd4:    result = 5'd31;
         4'd5:    result = 5'd30;
         4'd6:    result = 5'd31;
         4'd7:    result = 5'd31;
         4'd8:    result = 5'd30;
         4'd9:    result = 5'd31;
         4'd10:   result = 5'd30;
         4'd11:   result = 5'd31;
         default: result = 5'd31;
      endcase
      return result;
   endfunction

endpackage

[design/epoch_seconds_to_calendar_unit.sv]
// Top level of the converter from epoch seconds to local calendar date and time.
`timescale 1ns / 1ps

// The block turns a 32-bit count of seconds since 1970-01-01 UTC into the local
// year, month, day, weekday (1 is Monday, 7 is Sunday), hours, minutes and
// seconds. The signed 17-bit offset in the CSR (reset value +28800 s, eight
// hours) is added first, and the sum wraps modulo 2^32. The divisions and the
// year and month loops run on one shared 32-bit compare-and-subtract unit under
// a small sequencer: it divides by 86400, takes the day count modulo 7, steps
// off elapsed years from 1970 and then elapsed months, divides out hours and
// then minutes, and hands the item to the output register. The next item can
// be accepted in the cycle after the result is loaded. A new item is accepted
// once the previous one has moved to the output register, even while that
// result is still stalled. The offset must be written by the user only while
// the block is idle; the block itself does not enforce this.
module epoch_seconds_to_calendar_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Configuration port.
   input  logic                                 csr_wr_en,
   input  logic signed [ep2cal_pkg::OFFSET_W-1:0] csr_wr_data,
   // Input channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ep2cal_pkg::STAMP_W-1:0]       req_epoch_seconds,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ep2cal_pkg::YEAR_W-1:0]        rsp_year,
   output logic [ep2cal_pkg::MONTH_W-1:0]       rsp_month,
   output logic [ep2cal_pkg::DAY_W-1:0]         rsp_day,
   output logic [ep2cal_pkg::WEEKDAY_W-1:0]     rsp_weekday,
   output logic [ep2cal_pkg::HOURS_W-1:0]       rsp_hours,
   output logic [ep2cal_pkg::MINUTES_W-1:0]     rsp_minutes,
   output logic [ep2cal_pkg::SECONDS_W-1:0]     rsp_seconds
);
   import ep2cal_pkg::*;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DAYDIV = 3'd1;
   localparam logic [2:0] ST_WEEK   = 3'd2;
   localparam logic [2:0] ST_YEAR   = 3'd3;
   localparam logic [2:0] ST_MONTH  = 3'd4;
   localparam logic [2:0] ST_HOUR   = 3'd5;
   localparam logic [2:0] ST_MIN    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   // Highest shift of each shift-and-subtract division; the shift counts down to zero.
   localparam logic [3:0] DayDivTop  = 4'd15;
   localparam logic [3:0] WeekDivTop = 4'd13;
   localparam logic [3:0] HourDivTop = 4'd4;
   localparam logic [3:0] MinDivTop  = 4'd5;

   logic signed [OFFSET_W-1:0] offset_ff, offset_in;
   logic [2:0]                 state_ff, state_in;
   logic [3:0]                 k_ff, k_in;
   logic [STAMP_W-1:0]         acc_ff, acc_in;
   logic [15:0]                q_ff, q_in;
   logic [16:0]                sod_ff, sod_in;
   logic [2:0]                 wd_ff, wd_in;
   logic [YEAR_W-1:0]          year_ff, year_in;
   logic [MONTH_W-1:0]         mon_ff, mon_in;
   logic [DAY_W-1:0]           day_ff, day_in;
   logic [HOURS_W-1:0]         hours_ff, hours_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]          rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]         rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]           rsp_day_ff, rsp_day_in;
   logic [WEEKDAY_W-1:0]       rsp_weekday_ff, rsp_weekday_in;
   logic [HOURS_W-1:0]         rsp_hours_ff, rsp_hours_in;
   logic [MINUTES_W-1:0]       rsp_minutes_ff, rsp_minutes_in;
   logic [SECONDS_W-1:0]       rsp_seconds_ff, rsp_seconds_in;

   logic [STAMP_W-1:0]         sub_val;
   logic [STAMP_W:0]           diff;
   logic                       ge;
   logic [STAMP_W-1:0]         rem_next;
   logic [15:0]                q_shift;
   logic                       out_free;
   logic [STAMP_W-1:0]         local_stamp;

   // Operand of the shared subtractor, chosen by the current step.
   always_comb begin
      case (state_ff)
         ST_DAYDIV: sub_val = SecsPerDay << k_ff;
         ST_WEEK:   sub_val = DaysPerWeek << k_ff;
         ST_YEAR:   sub_val = {23'd0, year_len(year_ff)};
         ST_MONTH:  sub_val = {27'd0, month_len(mon_ff, is_leap(year_ff))};
         ST_HOUR:   sub_val = SecsPerHour << k_ff;
         ST_MIN:    sub_val = SecsPerMin << k_ff;
         default:   sub_val = '0;
      endcase
   end

   // Shared compare-and-subtract unit.
   assign diff     = {1'b0, acc_ff} - {1'b0, sub_val};
   assign ge       = ~diff[STAMP_W];
   assign rem_next = ge ? diff[STAMP_W-1:0] : acc_ff;
   assign q_shift  = {q_ff[14:0], ge};

   // Local stamp: sign-extended offset added modulo 2^32.
   assign local_stamp = req_epoch_seconds
                      + {{(STAMP_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};

   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Sequencer and datapath next-state logic.
   always_comb begin
      offset_in      = offset_ff;
      state_in       = state_ff;
      k_in           = k_ff;
      acc_in         = acc_ff;
      q_in           = q_ff;
      sod_in         = sod_ff;
      wd_in          = wd_ff;
      year_in        = year_ff;
      mon_in         = mon_ff;
      day_in         = day_ff;
      hours_in       = hours_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_year_in    = rsp_year_ff;
      rsp_month_in   = rsp_month_ff;
      rsp_day_in     = rsp_day_ff;
      rsp_weekday_in = rsp_weekday_ff;
      rsp_hours_in   = rsp_hours_ff;
      rsp_minutes_in = rsp_minutes_ff;
      rsp_seconds_in = rsp_seconds_ff;

      if (csr_wr_en) begin
         offset_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               acc_in   = local_stamp;
               q_in     = '0;
               k_in     = DayDivTop;
               state_in = ST_DAYDIV;
            end
         end
         // Whole days and second of the day.
         ST_DAYDIV: begin
            acc_in = rem_next;
            q_in   = q_shift;
            k_in   = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               sod_in   = rem_next[16:0];
               acc_in   = {16'd0, q_shift};
               k_in     = WeekDivTop;
               state_in = ST_WEEK;
            end
         end
         // Day count modulo 7; the day count stays in the quotient register.
         ST_WEEK: begin
            acc_in = rem_next;
            k_in   = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               wd_in    = rem_next[2:0];
               acc_in   = {16'd0, q_ff};
               year_in  = BaseYear;
               state_in = ST_YEAR;
            end
         end
         // Step off whole years from 1970.
         ST_YEAR: begin
            if (ge) begin
               acc_in  = rem_next;
               year_in = year_ff + 12'd1;
            end else begin
               mon_in   = '0;
               state_in = ST_MONTH;
            end
         end
         // Step off whole months; December takes whatever remains.
         ST_MONTH: begin
            if (!ge || mon_ff == LastMonthIdx) begin
               day_in   = acc_ff[DAY_W-1:0] + 5'd1;
               acc_in   = {15'd0, sod_ff};
               q_in     = '0;
               k_in     = HourDivTop;
               state_in = ST_HOUR;
            end else begin
               acc_in = rem_next;
               mon_in = mon_ff + 4'd1;
            end
         end
         // Hours of the day.
         ST_HOUR: begin
            acc_in = rem_next;
            q_in   = q_shift;
            k_in   = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               hours_in = q_shift[HOURS_W-1:0];
               q_in     = '0;
               k_in     = MinDivTop;
               state_in = ST_MIN;
            end
         end
         // Minutes; the remainder is the second.
         ST_MIN: begin
            acc_in = rem_next;
            q_in   = q_shift;
            k_in   = k_ff - 4'd1;
            if (k_ff == 4'd0) begin
               state_in = ST_DONE;
            end
         end
         // Hand the item to the output register once it is free.
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_year_in    = year_ff;
               rsp_month_in   = mon_ff + 4'd1;
               rsp_day_in     = day_ff;
               rsp_weekday_in = (wd_ff > 3'd3) ? wd_ff - 3'd3 : wd_ff + 3'd4;
               rsp_hours_in   = hours_ff;
               rsp_minutes_in = q_ff[MINUTES_W-1:0];
               rsp_seconds_in = acc_ff[SECONDS_W-1:0];
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OffsetReset;
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      acc_ff         <= acc_in;
      q_ff           <= q_in;
      sod_ff         <= sod_in;
      wd_ff          <= wd_in;
      year_ff        <= year_in;
      mon_ff         <= mon_in;
      day_ff         <= day_in;
      hours_ff       <= hours_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_month_ff   <= rsp_month_in;
      rsp_day_ff     <= rsp_day_in;
      rsp_weekday_ff <= rsp_weekday_in;
      rsp_hours_ff   <= rsp_hours_in;
      rsp_minutes_ff <= rsp_minutes_in;
      rsp_seconds_ff <= rsp_seconds_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_year    = rsp_year_ff;
   assign rsp_month   = rsp_month_ff;
   assign rsp_day     = rsp_day_ff;
   assign rsp_weekday = rsp_weekday_ff;
   assign rsp_hours   = rsp_hours_ff;
   assign rsp_minutes = rsp_minutes_ff;
   assign rsp_seconds = rsp_seconds_ff;

   // A new result only appears after the sequencer has finished an item.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result appeared without a finished item");

   // The year loop never runs past the last representable year.
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_YEAR) |-> (year_ff <= LastYear))
      else $error("year loop ran past range");

   // The month loop stops at December.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MONTH) |-> (mon_ff <= LastMonthIdx))
      else $error("month loop ran past December");

   // A delivered time of day is always well formed.
   a_time_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hours_ff < 5'd24) && (rsp_minutes_ff < 6'd60)
                       && (rsp_seconds_ff < 6'd60))
      else $error("time of day out of range");

endmodule
